// ===== rtl/vme_pkg.sv =====
// ----------------------------------------------------------------------------
// vme_pkg
// types, widths and register codes shared by the von mises stress pipeline
// ----------------------------------------------------------------------------
package vme_pkg;

    localparam int COMPONENT_WIDTH = 24;
    localparam int TAG_WIDTH       = 16;
    localparam int OUT_TAG_WIDTH   = 16;
    localparam int OUT_WIDTH       = 26;

    localparam int SCALE_WIDTH     = 17;
    localparam int SCALE_FRAC      = 16;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam int SQ_WIDTH        = 2 * COMPONENT_WIDTH;
    localparam int SUM_WIDTH       = SQ_WIDTH + 2;
    localparam int RAD_WIDTH       = 2 * COMPONENT_WIDTH + 2;
    localparam int ROOT_WIDTH      = COMPONENT_WIDTH + 1;
    localparam int PROD_WIDTH      = ROOT_WIDTH + SCALE_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REDUCED_MODE    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REDUCTION_SCALE = CFG_INDEX_WIDTH'(1);

    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);

    typedef struct packed {
        logic [TAG_WIDTH-1:0]              entry_tag;
        logic signed [COMPONENT_WIDTH-1:0] stress_xx;
        logic signed [COMPONENT_WIDTH-1:0] stress_yy;
        logic signed [COMPONENT_WIDTH-1:0] stress_zz;
        logic signed [COMPONENT_WIDTH-1:0] stress_xy;
        logic signed [COMPONENT_WIDTH-1:0] stress_xz;
        logic signed [COMPONENT_WIDTH-1:0] stress_yz;
    } stress_item_t;

    typedef struct packed {
        logic [OUT_TAG_WIDTH-1:0] entry_tag_out;
        logic [OUT_WIDTH-1:0]     equivalent_stress;
    } stress_result_t;

endpackage

// ===== rtl/von_mises_equivalent_stress.sv =====
// ----------------------------------------------------------------------------
// von_mises_equivalent_stress
// result_valid and result are registered behind s1 to s4, the root and s5
// throughput: one stress state per cycle, busy stays low
// the depth is set by the square root, one stage per root bit (25 stages)
// reset clears the pipeline valid bits, reduced mode off, scale 1.0
// results are not held off by the receiver, each shows for one cycle
// ----------------------------------------------------------------------------
module von_mises_equivalent_stress (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  vme_pkg::stress_item_t               item,
    output logic                                result_valid,
    output vme_pkg::stress_result_t             result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vme_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import vme_pkg::*;

    localparam int VAL_WIDTH = PROD_WIDTH - SCALE_FRAC;
    localparam int SAT_WIDTH = (VAL_WIDTH > OUT_WIDTH) ? VAL_WIDTH : OUT_WIDTH;
    localparam logic [SAT_WIDTH-1:0] SAT_LIMIT = SAT_WIDTH'({OUT_WIDTH{1'b1}});

    function automatic logic [COMPONENT_WIDTH-1:0] abs_diff(
        input logic signed [COMPONENT_WIDTH-1:0] a,
        input logic signed [COMPONENT_WIDTH-1:0] b
    );
        logic signed [COMPONENT_WIDTH:0] d;
        d = $signed({a[COMPONENT_WIDTH-1], a}) - $signed({b[COMPONENT_WIDTH-1], b});
        return d[COMPONENT_WIDTH] ? COMPONENT_WIDTH'(-d) : d[COMPONENT_WIDTH-1:0];
    endfunction

    logic                   accept;

    logic                   reduced_mode_reg;
    logic                   reduced_mode_next;
    logic [SCALE_WIDTH-1:0] reduction_scale_reg;
    logic [SCALE_WIDTH-1:0] reduction_scale_next;

    logic                       s1_valid_reg;
    logic [COMPONENT_WIDTH-1:0] mag_reg [6];
    logic [TAG_WIDTH-1:0]       s1_tag_reg;

    logic                       s2_valid_reg;
    logic [SQ_WIDTH-1:0]        sq_reg [6];
    logic [TAG_WIDTH-1:0]       s2_tag_reg;

    logic                       s3_valid_reg;
    logic [SUM_WIDTH-1:0]       normal_sum_reg;
    logic [SUM_WIDTH-1:0]       shear_sum_reg;
    logic [TAG_WIDTH-1:0]       s3_tag_reg;

    logic                       s4_valid_reg;
    logic [RAD_WIDTH-1:0]       rad_reg;
    logic [TAG_WIDTH-1:0]       s4_tag_reg;

    logic                       root_valid;
    logic [ROOT_WIDTH-1:0]      root;
    logic [TAG_WIDTH-1:0]       root_tag;

    logic                       s5_valid_reg;
    logic [PROD_WIDTH-1:0]      prod_reg;
    logic [ROOT_WIDTH-1:0]      s5_root_reg;
    logic [TAG_WIDTH-1:0]       s5_tag_reg;

    logic [SAT_WIDTH-1:0]       value;
    logic                       result_valid_reg;
    stress_result_t             result_reg;
    stress_result_t             result_next;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb
    begin
        reduced_mode_next    = reduced_mode_reg;
        reduction_scale_next = reduction_scale_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REDUCED_MODE:
                begin
                    reduced_mode_next = cfg_data[0];
                end
                REG_REDUCTION_SCALE:
                begin
                    reduction_scale_next = cfg_data[SCALE_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduced_mode_reg    <= 1'b0;
            reduction_scale_reg <= SCALE_RESET;
        end
        else
        begin
            reduced_mode_reg    <= reduced_mode_next;
            reduction_scale_reg <= reduction_scale_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= root_valid;
            result_valid_reg <= s5_valid_reg;
        end
    end

    // magnitudes of normal differences and shear components
    always_ff @(posedge clk)
    begin
        mag_reg[0] <= abs_diff(item.stress_xx, item.stress_yy);
        mag_reg[1] <= abs_diff(item.stress_yy, item.stress_zz);
        mag_reg[2] <= abs_diff(item.stress_zz, item.stress_xx);
        mag_reg[3] <= abs_diff(item.stress_xy, '0);
        mag_reg[4] <= abs_diff(item.stress_xz, '0);
        mag_reg[5] <= abs_diff(item.stress_yz, '0);
        s1_tag_reg <= item.entry_tag;
    end

    // squares
    for (genvar i = 0; i < 6; i++)
    begin : g_square
        always_ff @(posedge clk)
        begin
            sq_reg[i] <= SQ_WIDTH'(mag_reg[i]) * SQ_WIDTH'(mag_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tag_reg     <= s1_tag_reg;
        normal_sum_reg <= SUM_WIDTH'(sq_reg[0]) + SUM_WIDTH'(sq_reg[1])
                        + SUM_WIDTH'(sq_reg[2]);
        shear_sum_reg  <= SUM_WIDTH'(sq_reg[3]) + SUM_WIDTH'(sq_reg[4])
                        + SUM_WIDTH'(sq_reg[5]);
        s3_tag_reg     <= s2_tag_reg;
    end

    // half of the sum: normal part is even, shear part counts three times
    always_ff @(posedge clk)
    begin
        rad_reg    <= RAD_WIDTH'(normal_sum_reg >> 1) + RAD_WIDTH'(shear_sum_reg)
                    + (RAD_WIDTH'(shear_sum_reg) << 1);
        s4_tag_reg <= s3_tag_reg;
    end

    vme_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .radicand  (rad_reg),
        .in_tag    (s4_tag_reg),
        .out_valid (root_valid),
        .root      (root),
        .out_tag   (root_tag)
    );

    // reduction scale
    always_ff @(posedge clk)
    begin
        prod_reg    <= PROD_WIDTH'(root) * PROD_WIDTH'(reduction_scale_reg);
        s5_root_reg <= root;
        s5_tag_reg  <= root_tag;
    end

    // mode select and saturation
    always_comb
    begin
        value = reduced_mode_reg ? SAT_WIDTH'(prod_reg[PROD_WIDTH-1:SCALE_FRAC])
                                 : SAT_WIDTH'(s5_root_reg);
        result_next.entry_tag_out     = OUT_TAG_WIDTH'(s5_tag_reg);
        result_next.equivalent_stress = (value > SAT_LIMIT) ? {OUT_WIDTH{1'b1}}
                                                            : OUT_WIDTH'(value);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/vme_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// vme_sqrt_pipe
// pipelined integer square root, one root bit resolved per register stage
// ----------------------------------------------------------------------------
module vme_sqrt_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [vme_pkg::RAD_WIDTH-1:0]  radicand,
    input  logic [vme_pkg::TAG_WIDTH-1:0]  in_tag,
    output logic                           out_valid,
    output logic [vme_pkg::ROOT_WIDTH-1:0] root,
    output logic [vme_pkg::TAG_WIDTH-1:0]  out_tag
);
    import vme_pkg::*;

    logic                  stage_valid_reg [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] root_reg        [ROOT_WIDTH];
    logic [RAD_WIDTH-1:0]  rem_reg         [ROOT_WIDTH];
    logic [TAG_WIDTH-1:0]  tag_reg         [ROOT_WIDTH];

    for (genvar k = 0; k < ROOT_WIDTH; k++)
    begin : g_stage
        localparam int BIT = ROOT_WIDTH - 1 - k;

        logic                  src_valid;
        logic [ROOT_WIDTH-1:0] src_root;
        logic [RAD_WIDTH-1:0]  src_rem;
        logic [TAG_WIDTH-1:0]  src_tag;
        logic [RAD_WIDTH:0]    trial;
        logic                  fits;

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_root  = '0;
            assign src_rem   = radicand;
            assign src_tag   = in_tag;
        end
        else
        begin : g_next
            assign src_valid = stage_valid_reg[k-1];
            assign src_root  = root_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_tag   = tag_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
        always_comb
        begin
            trial = ((RAD_WIDTH + 1)'(src_root) << (BIT + 1))
                  | ((RAD_WIDTH + 1)'(1) << (2 * BIT));
            fits  = ({1'b0, src_rem} >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
            else
            begin
                stage_valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= fits ? (src_root | (ROOT_WIDTH'(1) << BIT)) : src_root;
            rem_reg[k]  <= fits ? (src_rem - trial[RAD_WIDTH-1:0]) : src_rem;
            tag_reg[k]  <= src_tag;
        end
    end

    assign out_valid = stage_valid_reg[ROOT_WIDTH-1];
    assign root      = root_reg[ROOT_WIDTH-1];
    assign out_tag   = tag_reg[ROOT_WIDTH-1];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the von mises equivalent stress pipeline: a table
// of directed stress states, some with known values, then random states over
// several register settings, the rest checked against a local predictor
// ----------------------------------------------------------------------------
module tb;

    import vme_pkg::*;

    localparam int PIPE_LATENCY  = 30;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 125;
    localparam int NUM_SETS      = 8;
    localparam int C_MAX         = 8388607;
    localparam int C_MIN         = -8388608;
    localparam longint OUT_MAX   = (64'd1 << OUT_WIDTH) - 1;

    typedef struct {
        bit                     mode;
        logic [SCALE_WIDTH-1:0] scale;
        stress_item_t           stim;
        bit                     fixed;
        logic [OUT_WIDTH-1:0]   value;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    stress_item_t                item;
    logic                        result_valid;
    stress_result_t              result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data;

    bit                          item_has_fixed;
    logic [OUT_WIDTH-1:0]        item_fixed_value;
    bit                          mirror_mode;
    logic [SCALE_WIDTH-1:0]      mirror_scale;
    stress_result_t              expected_results[$];
    stim_row_t                   directed_rows[$];
    int                          error_count;
    int                          cycle_count;

    von_mises_equivalent_stress uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic stress_result_t predict_stress(stress_item_t it, bit mode,
                                                      logic [SCALE_WIDTH-1:0] scale);
        stress_result_t r;
        longint xx;
        longint yy;
        longint zz;
        longint xy;
        longint xz;
        longint yz;
        longint sum;
        longint half;
        longint root;
        longint cand;
        longint val;
        xx = longint'(it.stress_xx);
        yy = longint'(it.stress_yy);
        zz = longint'(it.stress_zz);
        xy = longint'(it.stress_xy);
        xz = longint'(it.stress_xz);
        yz = longint'(it.stress_yz);
        sum = (xx - yy) * (xx - yy) + (yy - zz) * (yy - zz) + (zz - xx) * (zz - xx)
            + 6 * (xy * xy + xz * xz + yz * yz);
        half = sum >>> 1;
        root = 0;
        for (int b = 26; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= half)
                root = cand;
        end
        if (mode)
            val = (root * longint'({1'b0, scale})) >>> SCALE_FRAC;
        else
            val = root;
        if (val > OUT_MAX)
            val = OUT_MAX;
        r.entry_tag_out     = it.entry_tag;
        r.equivalent_stress = val[OUT_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [COMPONENT_WIDTH-1:0] rand_component();
        case ($urandom_range(0, 7))
            0: return COMPONENT_WIDTH'(C_MAX);
            1: return COMPONENT_WIDTH'(C_MIN);
            2: return COMPONENT_WIDTH'($urandom_range(0, 200) - 100);
            3: return '0;
            4: return COMPONENT_WIDTH'($urandom_range(0, 8191) - 4096);
            default: return COMPONENT_WIDTH'($urandom());
        endcase
    endfunction

    task automatic add_row(bit mode, int scale, int tag, int xx, int yy, int zz,
                           int xy, int xz, int yz, bit fixed, int value);
        stim_row_t row;
        row.mode            = mode;
        row.scale           = SCALE_WIDTH'(scale);
        row.stim.entry_tag  = TAG_WIDTH'(tag);
        row.stim.stress_xx  = COMPONENT_WIDTH'(xx);
        row.stim.stress_yy  = COMPONENT_WIDTH'(yy);
        row.stim.stress_zz  = COMPONENT_WIDTH'(zz);
        row.stim.stress_xy  = COMPONENT_WIDTH'(xy);
        row.stim.stress_xz  = COMPONENT_WIDTH'(xz);
        row.stim.stress_yz  = COMPONENT_WIDTH'(yz);
        row.fixed           = fixed;
        row.value           = OUT_WIDTH'(value);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_stress(stress_item_t it, bit fixed, logic [OUT_WIDTH-1:0] value,
                               bit allow_idle);
        int gap;
        @(negedge clk);
        if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            gap   = $urandom_range(1, 18);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start            = 1'b1;
        item             = it;
        item_has_fixed   = fixed;
        item_fixed_value = value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_REDUCED_MODE)
            mirror_mode = data[0];
        else if (idx == REG_REDUCTION_SCALE)
            mirror_scale = data[SCALE_WIDTH-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(bit mode, logic [SCALE_WIDTH-1:0] scale);
        wait_drained();
        // writes to unused indexes must leave both registers alone
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_INDEX_WIDTH'($urandom_range(2, 255)), $urandom());
        if (scale != mirror_scale)
            write_reg(REG_REDUCTION_SCALE,
                      ($urandom() & ~CFG_DATA_WIDTH'(32'h1FFFF)) | CFG_DATA_WIDTH'(scale));
        if (mode != mirror_mode)
            write_reg(REG_REDUCED_MODE,
                      ($urandom() & ~CFG_DATA_WIDTH'(1)) | CFG_DATA_WIDTH'(mode));
    endtask

    always @(posedge clk)
    begin : check_results
        stress_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (item_has_fixed)
                begin
                    want.entry_tag_out     = item.entry_tag;
                    want.equivalent_stress = item_fixed_value;
                end
                else
                    want = predict_stress(item, mirror_mode, mirror_scale);
                expected_results.insert(expected_results.size(), want);
            end
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tag %0d stress %0d",
                             $time, result.entry_tag_out, result.equivalent_stress);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.entry_tag_out !== want.entry_tag_out)
                    begin
                        $display("%0t: tag mismatch, expected %0d actual %0d",
                                 $time, want.entry_tag_out, result.entry_tag_out);
                        error_count++;
                    end
                    if (result.equivalent_stress !== want.equivalent_stress)
                    begin
                        $display("%0t: stress mismatch (tag %0d), expected %0d actual %0d",
                                 $time, want.entry_tag_out, want.equivalent_stress,
                                 result.equivalent_stress);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        stress_item_t           it;
        bit                     idle_on;
        bit                     set_mode;
        logic [SCALE_WIDTH-1:0] set_scale;

        rst_n            = 1'b0;
        start            = 1'b0;
        item             = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        item_has_fixed   = 1'b0;
        item_fixed_value = '0;
        mirror_mode      = 1'b0;
        mirror_scale     = SCALE_RESET;
        error_count      = 0;

        // reset values: plain mode, scale 1.0
        add_row(0, 65536, 16'h0000, 0, 0, 0, 0, 0, 0, 1, 0);
        add_row(0, 65536, 16'hFFFF, C_MAX, 0, 0, 0, 0, 0, 1, C_MAX);
        add_row(0, 65536, 16'h0001, C_MIN, 0, 0, 0, 0, 0, 1, 8388608);
        add_row(0, 65536, 16'h5555, 0, 0, 0, C_MAX, C_MAX, C_MAX, 1, 3 * C_MAX);
        add_row(0, 65536, 16'hAAAA, 0, 0, 0, C_MIN, C_MIN, C_MIN, 1, 25165824);
        add_row(0, 65536, 16'h00FF, C_MIN, C_MIN, C_MIN, 0, 0, 0, 1, 0);
        add_row(0, 65536, 16'hFF00, C_MAX, C_MAX, C_MAX, 0, 0, 0, 1, 0);
        add_row(0, 65536, 16'h1234, C_MAX, C_MIN, 0, C_MIN, C_MIN, C_MIN, 0, 0);
        add_row(0, 65536, 16'h0002, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(0, 65536, 16'h0003, 1, 0, -1, 0, -1, 1, 0, 0);
        add_row(0, 65536, 16'h7FFF, -123456, 654321, 42, -999, 77777, -3, 0, 0);
        // reduced mode with the scale left at its reset value
        add_row(1, 65536, 16'h8000, C_MAX, 0, 0, 0, 0, 0, 1, C_MAX);
        add_row(1, 65536, 16'h8001, 1000, -2000, 3000, 4, -5, 6, 0, 0);
        // zero scale
        add_row(1, 0, 16'h8002, 0, 0, 0, C_MIN, C_MIN, C_MIN, 1, 0);
        add_row(1, 0, 16'h8003, C_MAX, C_MIN, 0, C_MAX, C_MIN, C_MAX, 1, 0);
        // largest scale, then half and the smallest nonzero scale
        add_row(1, 131071, 16'h8004, 0, 0, 0, C_MIN, C_MIN, C_MIN, 0, 0);
        add_row(1, 131071, 16'h8005, C_MAX, C_MIN, 0, C_MIN, C_MIN, C_MIN, 0, 0);
        add_row(1, 32768, 16'h8006, C_MIN, 0, 0, 0, 0, 0, 1, 4194304);
        add_row(1, 1, 16'h8007, C_MAX, 0, 0, 0, 0, 0, 0, 0);
        // plain mode ignores the scale
        add_row(0, 131071, 16'h8008, C_MAX, 0, 0, 0, 0, 0, 1, C_MAX);
        add_row(0, 131071, 16'hC3A5, 5, C_MAX, C_MIN, -7, 8, C_MAX, 0, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != mirror_mode || directed_rows[i].scale != mirror_scale)
                apply_setting(directed_rows[i].mode, directed_rows[i].scale);
            send_stress(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].value,
                        1'b1);
        end

        for (int s = 0; s < NUM_SETS; s++)
        begin
            case (s)
                0: begin set_mode = 1'b0; set_scale = SCALE_RESET; end
                1: begin set_mode = 1'b1; set_scale = SCALE_WIDTH'(131071); end
                2: begin set_mode = 1'b1; set_scale = '0; end
                3: begin set_mode = 1'b1; set_scale = SCALE_WIDTH'($urandom()); end
                4: begin set_mode = 1'b0; set_scale = SCALE_WIDTH'($urandom()); end
                5: begin set_mode = 1'b1; set_scale = SCALE_RESET; end
                default:
                begin
                    set_mode  = 1'b1;
                    set_scale = SCALE_WIDTH'($urandom_range(1, 131071));
                end
            endcase
            apply_setting(set_mode, set_scale);
            // the last set runs back to back
            idle_on = (s != NUM_SETS - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                it.entry_tag = TAG_WIDTH'($urandom());
                it.stress_xx = rand_component();
                it.stress_yy = rand_component();
                it.stress_zz = rand_component();
                it.stress_xy = rand_component();
                it.stress_xz = rand_component();
                it.stress_yz = rand_component();
                // hydrostatic states cancel the normal terms
                if ($urandom_range(0, 9) == 0)
                begin
                    it.stress_yy = it.stress_xx;
                    it.stress_zz = it.stress_xx;
                end
                send_stress(it, 1'b0, '0, idle_on);
            end
        end

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(negedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vme_pkg.sv
rtl/vme_sqrt_pipe.sv
rtl/von_mises_equivalent_stress.sv
tb/tb.sv
